FILE: hdl/de_mutation_crossover_element_core_assert.svh
// Assertion shorthands for the trial-element core.
// Each checks on the rising edge of aclk and is quiet while aresetn is low.
`ifndef DE_MUTATION_CROSSOVER_ELEMENT_CORE_ASSERT_SVH
`define DE_MUTATION_CROSSOVER_ELEMENT_CORE_ASSERT_SVH
`ifndef SYNTH
`define DEMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("demc: same-cycle check failed");
`define DEMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("demc: next-cycle check failed");
`else
`define DEMC_ASSERT_IMP(lbl, ante, cons)
`define DEMC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/demc_pkg.sv
`default_nettype none
package demc_pkg;

    localparam int VALUE_FRAC_BITS_DEF = 16;
    localparam int SCALE_FRAC_BITS     = 16;
    localparam int DEFAULT_RANGE       = 100;

    localparam int VALUE_W = 32;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int SCALE_W = 18;
    localparam int RATE_W  = 17;
    localparam int DRAW_W  = 16;
    localparam int PROD_W  = DIFF_W + SCALE_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int RND_W   = ACC_W - SCALE_FRAC_BITS;
    localparam int MUT_W   = RND_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(58982);

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [3:0] {
        STRAT_CUR1       = 4'd0,
        STRAT_CUR2       = 4'd1,
        STRAT_CUR_BEST1  = 4'd2,
        STRAT_CUR_BEST2  = 4'd3,
        STRAT_RAND1      = 4'd4,
        STRAT_RAND2      = 4'd5,
        STRAT_BEST1      = 4'd6,
        STRAT_BEST2      = 4'd7,
        STRAT_CUR_RAND1  = 4'd8,
        STRAT_MOD_RAND1  = 4'd9
    } strategy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRATEGY = 3'd0,
        REG_SCALE    = 3'd1,
        REG_RATE     = 3'd2,
        REG_LOWER    = 3'd3,
        REG_UPPER    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [3:0]                strategy;
        logic [SCALE_W-1:0]        scale;
        logic [RATE_W-1:0]         rate;
        logic signed [VALUE_W-1:0] lower;
        logic signed [VALUE_W-1:0] upper;
    } cfg_t;

    // One classified request: base term, current value, three differences, scale and crossover pick.
    typedef struct packed {
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] cur;
        logic signed [DIFF_W-1:0]  diff0;
        logic signed [DIFF_W-1:0]  diff1;
        logic signed [DIFF_W-1:0]  diff2;
        logic [SCALE_W-1:0]        scale;
        logic                      take;
    } job_t;

endpackage
`default_nettype wire

FILE: hdl/demc_front.sv
`default_nettype none
module demc_front import demc_pkg::*; (
    input  cfg_t                      cfg,
    input  logic signed [VALUE_W-1:0] current_value,
    input  logic signed [VALUE_W-1:0] best_value,
    input  logic signed [VALUE_W-1:0] donor_a,
    input  logic signed [VALUE_W-1:0] donor_b,
    input  logic signed [VALUE_W-1:0] donor_c,
    input  logic signed [VALUE_W-1:0] donor_d,
    input  logic signed [VALUE_W-1:0] donor_e,
    input  logic [DRAW_W-1:0]         crossover_draw,
    input  logic                      forced_position,
    input  logic [SCALE_W-1:0]        scale_draw,
    input  logic [RATE_W-1:0]         rate_draw,
    output job_t                      job
);

    logic signed [DIFF_W-1:0] d_ab, d_cd, d_bc, d_de, d_best_cur, d_a_cur;
    logic [RATE_W-1:0]        rate_use;

    assign d_ab       = {donor_a[VALUE_W-1], donor_a} - {donor_b[VALUE_W-1], donor_b};
    assign d_cd       = {donor_c[VALUE_W-1], donor_c} - {donor_d[VALUE_W-1], donor_d};
    assign d_bc       = {donor_b[VALUE_W-1], donor_b} - {donor_c[VALUE_W-1], donor_c};
    assign d_de       = {donor_d[VALUE_W-1], donor_d} - {donor_e[VALUE_W-1], donor_e};
    assign d_best_cur = {best_value[VALUE_W-1], best_value}
                        - {current_value[VALUE_W-1], current_value};
    assign d_a_cur    = {donor_a[VALUE_W-1], donor_a}
                        - {current_value[VALUE_W-1], current_value};

    always_comb begin
        job.base  = current_value;
        job.cur   = current_value;
        job.diff0 = '0;
        job.diff1 = '0;
        job.diff2 = '0;
        job.scale = cfg.scale;
        rate_use  = cfg.rate;
        case (strategy_t'(cfg.strategy))
            STRAT_CUR1: begin
                job.diff0 = d_ab;
            end
            STRAT_CUR2: begin
                job.diff0 = d_ab;
                job.diff1 = d_cd;
            end
            STRAT_CUR_BEST1: begin
                job.diff0 = d_best_cur;
                job.diff1 = d_ab;
            end
            STRAT_CUR_BEST2: begin
                job.diff0 = d_best_cur;
                job.diff1 = d_ab;
                job.diff2 = d_cd;
            end
            STRAT_RAND1: begin
                job.base  = donor_a;
                job.diff0 = d_bc;
            end
            STRAT_RAND2: begin
                job.base  = donor_a;
                job.diff0 = d_bc;
                job.diff1 = d_de;
            end
            STRAT_BEST1: begin
                job.base  = best_value;
                job.diff0 = d_ab;
            end
            STRAT_BEST2: begin
                job.base  = best_value;
                job.diff0 = d_ab;
                job.diff1 = d_cd;
            end
            STRAT_CUR_RAND1: begin
                job.diff0 = d_a_cur;
                job.diff1 = d_bc;
                job.diff2 = d_de;
            end
            STRAT_MOD_RAND1: begin
                job.diff0 = d_a_cur;
                job.scale = scale_draw;
                rate_use  = rate_draw;
            end
            default: begin
                // unused codes: mutant is the current value
                job.diff0 = '0;
            end
        endcase
        job.take = forced_position || ({1'b0, crossover_draw} <= rate_use);
    end

endmodule
`default_nettype wire

FILE: hdl/demc_queue.sv
`default_nettype none
`include "de_mutation_crossover_element_core_assert.svh"
module demc_queue import demc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DEMC_ASSERT_IMP(a_no_pop_empty, pop, !empty)
    `DEMC_ASSERT_NXT(a_push_fills, (push && !pop), (count_reg != '0))

endmodule
`default_nettype wire

FILE: hdl/demc_back.sv
`default_nettype none
`include "de_mutation_crossover_element_core_assert.svh"
module demc_back import demc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic signed [VALUE_W-1:0] lower,
    input  logic signed [VALUE_W-1:0] upper,
    input  logic                      in_valid,
    input  job_t                      in_job,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_trial_value
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SCALE_FRAC_BITS - 1);

    // stage A: products
    logic                      a_valid_reg;
    logic signed [PROD_W-1:0]  a_prod0_reg, a_prod1_reg, a_prod2_reg;
    logic signed [VALUE_W-1:0] a_base_reg, a_cur_reg;
    logic                      a_take_reg;
    // stage B: rounded sum, crossover
    logic                      b_valid_reg;
    logic signed [MUT_W-1:0]   b_value_reg;
    // stage C: clamped result
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_trial_reg;

    logic a_ready, b_ready, c_ready, a_load, b_load, c_load;
    logic signed [SCALE_W:0]  scale_s;
    logic signed [PROD_W-1:0] prod0, prod1, prod2;
    logic signed [ACC_W-1:0]  acc, acc_rnd;
    logic signed [RND_W-1:0]  rnd;
    logic signed [MUT_W-1:0]  mutant, chosen, lo_x, hi_x, clamped;

    assign c_ready  = !m_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_load   = in_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;
    assign c_load   = b_valid_reg && c_ready;

    assign scale_s = $signed({1'b0, in_job.scale});
    assign prod0   = in_job.diff0 * scale_s;
    assign prod1   = in_job.diff1 * scale_s;
    assign prod2   = in_job.diff2 * scale_s;

    // floor((sum + half) / 2^frac): ties go up
    assign acc     = {{2{a_prod0_reg[PROD_W-1]}}, a_prod0_reg}
                   + {{2{a_prod1_reg[PROD_W-1]}}, a_prod1_reg}
                   + {{2{a_prod2_reg[PROD_W-1]}}, a_prod2_reg};
    assign acc_rnd = acc + ROUND_HALF;
    assign rnd     = acc_rnd[ACC_W-1:SCALE_FRAC_BITS];
    assign mutant  = {{(MUT_W-VALUE_W){a_base_reg[VALUE_W-1]}}, a_base_reg}
                   + {rnd[RND_W-1], rnd};
    assign chosen  = a_take_reg ? mutant
                   : {{(MUT_W-VALUE_W){a_cur_reg[VALUE_W-1]}}, a_cur_reg};

    assign lo_x = {{(MUT_W-VALUE_W){lower[VALUE_W-1]}}, lower};
    assign hi_x = {{(MUT_W-VALUE_W){upper[VALUE_W-1]}}, upper};

    always_comb begin
        clamped = b_value_reg;
        if (clamped < lo_x) begin
            clamped = lo_x;
        end
        if (clamped > hi_x) begin
            clamped = hi_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_prod0_reg <= prod0;
            a_prod1_reg <= prod1;
            a_prod2_reg <= prod2;
            a_base_reg  <= in_job.base;
            a_cur_reg   <= in_job.cur;
            a_take_reg  <= in_job.take;
        end
        if (b_load) begin
            b_value_reg <= chosen;
        end
        if (c_load) begin
            m_trial_reg <= clamped[VALUE_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_trial_value = m_trial_reg;

    `DEMC_ASSERT_IMP(a_result_in_bounds, (m_valid_reg && (lower <= upper)), ((m_trial_reg >= lower) && (m_trial_reg <= upper)))
    `DEMC_ASSERT_IMP(a_crossed_bounds, (m_valid_reg && (lower > upper)), (m_trial_reg == upper))

endmodule
`default_nettype wire

FILE: hdl/de_mutation_crossover_element_core.sv
// Differential evolution trial-element core: mutation, binomial crossover, clamp.
// Input channel (s_valid/s_ready): one request per dimension holding the target,
//   best and five donor elements (signed Q16.16), a Q0.16 crossover draw, the
//   forced-position flag and the per-individual scale and rate draws.
// Result channel (m_valid/m_ready): one clamped trial element per request, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): strategy, scale F,
//   crossover rate CR, lower and upper bound; always ready. Write only while idle.
// Throughput: one request per cycle while s_ready is high; the front classifies
//   and queues in the accept cycle, the back runs multiply, sum/round/crossover
//   and clamp stages.
// A 4-entry queue parts front and back: when m_ready is low the back pipeline
//   holds, the queue soaks up requests and s_ready drops only once it is full.
// Reset (aresetn low, synchronous): queue and pipeline empty, strategy 0,
//   F = 0.5, CR = 58982/65536, bounds = -/+100.0 in the value format.
`default_nettype none
module de_mutation_crossover_element_core import demc_pkg::*; #(
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_current_value,
    input  logic signed [VALUE_W-1:0] s_best_value,
    input  logic signed [VALUE_W-1:0] s_donor_a,
    input  logic signed [VALUE_W-1:0] s_donor_b,
    input  logic signed [VALUE_W-1:0] s_donor_c,
    input  logic signed [VALUE_W-1:0] s_donor_d,
    input  logic signed [VALUE_W-1:0] s_donor_e,
    input  logic [DRAW_W-1:0]         s_crossover_draw,
    input  logic                      s_forced_position,
    input  logic [SCALE_W-1:0]        s_scale_draw,
    input  logic [RATE_W-1:0]         s_rate_draw,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_trial_value,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [VALUE_W-1:0]        cfg_data
);

    // +/- DEFAULT_RANGE in the value format
    localparam logic [VALUE_W-1:0] BOUND_RESET = VALUE_W'(DEFAULT_RANGE << VALUE_FRAC_BITS);

    cfg_t cfg_reg, cfg_next;
    job_t front_job, queue_job;
    logic q_push, q_pop, q_full, q_empty, back_ready;

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_STRATEGY: cfg_next.strategy = cfg_data[3:0];
                REG_SCALE:    cfg_next.scale    = cfg_data[SCALE_W-1:0];
                REG_RATE:     cfg_next.rate     = cfg_data[RATE_W-1:0];
                REG_LOWER:    cfg_next.lower    = $signed(cfg_data);
                REG_UPPER:    cfg_next.upper    = $signed(cfg_data);
                default:      cfg_next          = cfg_reg; // out-of-range index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strategy <= STRAT_CUR1;
            cfg_reg.scale    <= SCALE_RESET;
            cfg_reg.rate     <= RATE_RESET;
            cfg_reg.lower    <= $signed(~BOUND_RESET + 1'b1);
            cfg_reg.upper    <= $signed(BOUND_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- front: classify request ----------------
    demc_front u_front (
        .cfg             (cfg_reg),
        .current_value   (s_current_value),
        .best_value      (s_best_value),
        .donor_a         (s_donor_a),
        .donor_b         (s_donor_b),
        .donor_c         (s_donor_c),
        .donor_d         (s_donor_d),
        .donor_e         (s_donor_e),
        .crossover_draw  (s_crossover_draw),
        .forced_position (s_forced_position),
        .scale_draw      (s_scale_draw),
        .rate_draw       (s_rate_draw),
        .job             (front_job)
    );

    // s_ready depends only on queue occupancy, never on m_ready
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign q_pop   = !q_empty && back_ready;

    // ---------------- queue between front and back ----------------
    demc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .pop_job  (queue_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // ---------------- back: arithmetic pipeline ----------------
    demc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lower         (cfg_reg.lower),
        .upper         (cfg_reg.upper),
        .in_valid      (!q_empty),
        .in_job        (queue_job),
        .in_ready      (back_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trial_value (m_trial_value)
    );

endmodule
`default_nettype wire
